// ===== src/kmsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the keypad matrix scan controller.
// No dependencies; kmsc_core, the top level and the testbench import this package.
package kmsc_pkg;

	localparam int MAX_ROWS    = 16;
	localparam int ROW_W       = 16;
	localparam int NUM_ROWS    = 16;
	localparam int ROW_IDX_W   = $clog2(NUM_ROWS);
	localparam int BANK_DEPTH  = NUM_ROWS / 2;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);
	localparam int CNT_W       = 17;
	localparam int ADDR_W      = 7;
	localparam int DATA_W      = 32;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	localparam logic [ADDR_W-1:0] ADDR_CONTROL   = 7'h00;
	localparam logic [ADDR_W-1:0] ADDR_SIZE      = 7'h04;
	localparam logic [ADDR_W-1:0] ADDR_STATUS    = 7'h08;
	localparam logic [ADDR_W-1:0] ADDR_ENABLE    = 7'h0C;
	localparam logic [ADDR_W-1:0] ADDR_ROWS_LO   = 7'h10;
	localparam logic [ADDR_W-1:0] ADDR_ROWS_HI   = 7'h2C;
	localparam logic [ADDR_W-1:0] ADDR_RSV_30    = 7'h30;
	localparam logic [ADDR_W-1:0] ADDR_RSV_34    = 7'h34;
	localparam logic [ADDR_W-1:0] ADDR_RSV_38    = 7'h38;
	localparam logic [ADDR_W-1:0] ADDR_RSV_3C    = 7'h3C;
	localparam logic [ADDR_W-1:0] ADDR_GPIO_EN   = 7'h40;
	localparam logic [ADDR_W-1:0] ADDR_GPIO_STAT = 7'h44;
	localparam logic [ADDR_W-1:0] ADDR_RSV_48    = 7'h48;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
		logic [ROW_W-1:0]  keys;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0]    read_data;
		logic                 bad_access;
		logic                 irq;
		logic [ROW_IDX_W-1:0] scan_row;
	} result_t;

	typedef struct packed {
		logic                 we;
		logic [ROW_IDX_W-1:0] addr;
		logic [ROW_W-1:0]     data;
	} row_wr_t;

endpackage

// ===== src/kmsc_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports, write-first.
// No dependencies.
module kmsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
			rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
		end
	end

endmodule

// ===== src/kmsc_core.sv =====
`timescale 1ns / 1ps
// Register file, scan timer and row scan logic: one item per fire.
// Depends on kmsc_pkg; row data comes from the RAM banks in the top level.
module kmsc_core import kmsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  item_t                item,
	input  logic                 invert,
	input  logic [ROW_W-1:0]     old_row,
	input  logic [DATA_W-1:0]    row_pair,
	output result_t              result,
	output row_wr_t              row_wr,
	output logic [ROW_IDX_W-1:0] row_nxt
);

	localparam logic [7:0] MAX_ROWS_B = 8'(MAX_ROWS);

	logic [DATA_W-1:0]    control_q, control_d;
	logic [DATA_W-1:0]    size_q, size_d;
	logic [1:0]           status_q, status_d;
	logic [2:0]           enable_q, enable_d;
	logic [DATA_W-1:0]    gpio_q, gpio_d;
	logic [ROW_IDX_W-1:0] row_q, row_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic                 run_q, run_d;

	logic [DATA_W-1:0]    rd;
	logic                 bad;
	logic [ROW_W-1:0]     scan_val;
	logic [ROW_IDX_W:0]   next_row;
	logic [7:0]           row_cnt;
	logic                 in_rows;
	logic                 do_scan;

	function automatic logic [13:0] row_delay(input logic [DATA_W-1:0] ctrl);
		logic [13:0] d;
		d = ctrl[15:2];
		return (d == 14'd0) ? 14'd1 : d;
	endfunction

	function automatic logic [CNT_W-1:0] frame_delay(input logic [DATA_W-1:0] ctrl);
		return {1'b0, ctrl[31:16]} + {3'b000, row_delay(ctrl)};
	endfunction

	function automatic logic [ROW_W-1:0] scan_value(
		input logic [ROW_W-1:0]     keys,
		input logic [ROW_IDX_W-1:0] r,
		input logic [DATA_W-1:0]    size,
		input logic                 inv
	);
		logic [19:0]      glitch;
		logic [ROW_W-1:0] row;
		logic [7:0]       cols;
		glitch = 20'h80000 >> r;
		row = ~keys & ~glitch[ROW_W-1:0];
		cols = size[15:8];
		if (cols < 8'd16) begin
			row = row | (16'hFFFF << cols[3:0]);
		end
		if (inv) begin
			row = ~row;
		end
		return row;
	endfunction

	assign scan_val = scan_value(item.keys, row_q, size_q, invert);
	assign next_row = {1'b0, row_q} + 5'd1;
	assign row_cnt  = (size_q[7:0] > MAX_ROWS_B) ? MAX_ROWS_B : size_q[7:0];
	assign in_rows  = (item.addr >= ADDR_ROWS_LO) && (item.addr <= ADDR_ROWS_HI)
		&& (item.addr[1:0] == 2'b00);

	always_comb begin
		control_d = control_q;
		size_d    = size_q;
		status_d  = status_q;
		enable_d  = enable_q;
		gpio_d    = gpio_q;
		row_d     = row_q;
		count_d   = count_q;
		run_d     = run_q;
		rd        = '0;
		bad       = 1'b0;
		do_scan   = 1'b0;
		unique case (item.cmd)
			CMD_READ: begin
				priority if (in_rows) begin
					rd = row_pair;
				end else begin
					unique case (item.addr)
						ADDR_CONTROL: rd = control_q;
						ADDR_SIZE:    rd = size_q;
						ADDR_STATUS:  rd = {30'd0, status_q};
						ADDR_ENABLE:  rd = {29'd0, enable_q};
						ADDR_GPIO_EN: rd = gpio_q;
						ADDR_RSV_30, ADDR_RSV_34, ADDR_RSV_38, ADDR_RSV_3C,
						ADDR_GPIO_STAT, ADDR_RSV_48: rd = '0;
						default:      bad = 1'b1;
					endcase
				end
			end
			CMD_WRITE: begin
				unique case (item.addr)
					ADDR_CONTROL: begin
						control_d = item.wdata;
						if (item.wdata[1]) begin
							count_d = frame_delay(item.wdata);
							run_d   = 1'b1;
						end else begin
							count_d = '0;
							run_d   = 1'b0;
						end
					end
					ADDR_SIZE:    size_d   = item.wdata;
					ADDR_STATUS:  status_d = status_q & ~item.wdata[1:0];
					ADDR_ENABLE:  enable_d = item.wdata[2:0];
					ADDR_GPIO_EN: gpio_d   = item.wdata;
					ADDR_RSV_30, ADDR_RSV_34, ADDR_RSV_3C,
					ADDR_GPIO_STAT, ADDR_RSV_48: bad = 1'b0;
					default:      bad = 1'b1;
				endcase
			end
			CMD_TICK: begin
				if (run_q) begin
					if (count_q <= 17'd1) begin
						do_scan = 1'b1;
						if (old_row != scan_val) begin
							status_d[1] = 1'b1;
						end
						if ({3'b000, next_row} < row_cnt) begin
							row_d   = next_row[ROW_IDX_W-1:0];
							count_d = {3'b000, row_delay(control_q)};
						end else begin
							row_d       = '0;
							status_d[0] = 1'b1;
							if (control_q[0]) begin
								count_d = frame_delay(control_q);
							end else begin
								control_d[1:0] = 2'b00;
								run_d          = 1'b0;
								count_d        = '0;
							end
						end
					end else begin
						count_d = count_q - 17'd1;
					end
				end
			end
			default: bad = 1'b0;
		endcase
	end

	assign row_wr.we   = fire && do_scan && (old_row != scan_val);
	assign row_wr.addr = row_q;
	assign row_wr.data = scan_val;

	assign result.read_data  = rd;
	assign result.bad_access = bad;
	assign result.irq        = |(enable_d & {1'b0, status_d});
	assign result.scan_row   = row_d;

	assign row_nxt = fire ? row_d : row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			size_q    <= '0;
			status_q  <= '0;
			enable_q  <= '0;
			gpio_q    <= '0;
			row_q     <= '0;
			count_q   <= '0;
			run_q     <= 1'b0;
		end else if (fire) begin
			control_q <= control_d;
			size_q    <= size_d;
			status_q  <= status_d;
			enable_q  <= enable_d;
			gpio_q    <= gpio_d;
			row_q     <= row_d;
			count_q   <= count_d;
			run_q     <= run_d;
		end
	end

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		run_q == (count_q != '0))
		else $error("timer running flag disagrees with countdown");

	a_run_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		run_q == control_q[1])
		else $error("timer running flag disagrees with control start bit");

endmodule

// ===== src/keypad_matrix_scan_controller_top.sv =====
`timescale 1ns / 1ps
// Top level of the keypad matrix scan controller: input and result registers,
// row store banks. Depends on kmsc_pkg, kmsc_ram and kmsc_core.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+-------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser cmd, tdata addr/wdata/keys
//  m_       | out       | m_tvalid/m_tready  | tdata read_data/bad/irq/scan_row
//  cfg_     | in        | cfg_we             | cfg_data invert_columns
//
// One item per cycle sustained while m_tready is high; the result is offered once
// the item has passed the input register (with the row store read) and the register
// file update into the result register. The row store is two 8-entry banks.
// Reset clears the valid flags, the register file and the row valid bits, so unwritten rows read 0.
// When m_tready is low the result holds; one more item enters the input
// register, then s_tready drops until the result is taken.
module keypad_matrix_scan_controller_top import kmsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // addr[6:0], write_data[38:7], key_columns[54:39], pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // read_data[31:0], bad_access, irq, scan_row[37:34], pad
);

	logic                 invert_q;
	logic                 s1_valid_q;
	item_t                item_s1;
	item_t                in_item;
	logic                 s_acc;
	logic                 s1_adv;
	logic                 m_valid_q;
	result_t              out_q;
	result_t              result;
	row_wr_t              row_wr;
	logic [ROW_IDX_W-1:0] row_nxt;
	logic [BANK_AW-1:0]   pair_idx;
	logic [NUM_ROWS-1:0]  row_vld_q, row_vld_d;
	logic                 vld_ae_s1, vld_ao_s1, vld_be_s1, vld_bo_s1;
	logic                 sel_odd_s1;
	logic [ROW_W-1:0]     even_a, even_b, odd_a, odd_b;
	logic [ROW_W-1:0]     old_row;
	logic [DATA_W-1:0]    row_pair;

	assign in_item.cmd   = cmd_t'(s_tuser);
	assign in_item.addr  = s_tdata[6:0];
	assign in_item.wdata = s_tdata[38:7];
	assign in_item.keys  = s_tdata[54:39];

	assign s1_adv   = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign s_acc    = s_tvalid && s_tready;
	assign pair_idx = BANK_AW'(in_item.addr[5:2] - 4'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q   <= 1'b0;
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
			row_vld_q  <= '0;
		end else begin
			if (cfg_we) begin
				invert_q <= cfg_data;
			end
			if (s_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			row_vld_q <= row_vld_d;
		end
	end

	assign row_vld_d = row_vld_q
		| (row_wr.we ? (NUM_ROWS'(1) << row_wr.addr) : '0);

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1    <= in_item;
			sel_odd_s1 <= row_nxt[0];
			vld_ae_s1  <= row_vld_d[{row_nxt[ROW_IDX_W-1:1], 1'b0}];
			vld_ao_s1  <= row_vld_d[{row_nxt[ROW_IDX_W-1:1], 1'b1}];
			vld_be_s1  <= row_vld_d[{pair_idx, 1'b0}];
			vld_bo_s1  <= row_vld_d[{pair_idx, 1'b1}];
		end
		if (s1_adv) begin
			out_q <= result;
		end
	end

	kmsc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BANK_DEPTH)
	) u_even (
		.clk     (clk),
		.we      (row_wr.we && !row_wr.addr[0]),
		.waddr   (row_wr.addr[ROW_IDX_W-1:1]),
		.wdata   (row_wr.data),
		.re      (s_acc),
		.raddr_a (row_nxt[ROW_IDX_W-1:1]),
		.raddr_b (pair_idx),
		.rdata_a (even_a),
		.rdata_b (even_b)
	);

	kmsc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BANK_DEPTH)
	) u_odd (
		.clk     (clk),
		.we      (row_wr.we && row_wr.addr[0]),
		.waddr   (row_wr.addr[ROW_IDX_W-1:1]),
		.wdata   (row_wr.data),
		.re      (s_acc),
		.raddr_a (row_nxt[ROW_IDX_W-1:1]),
		.raddr_b (pair_idx),
		.rdata_a (odd_a),
		.rdata_b (odd_b)
	);

	assign old_row = sel_odd_s1 ? (vld_ao_s1 ? odd_a : '0) : (vld_ae_s1 ? even_a : '0);
	assign row_pair = {(vld_bo_s1 ? odd_b : 16'd0), (vld_be_s1 ? even_b : 16'd0)};

	kmsc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (s1_adv),
		.item     (item_s1),
		.invert   (invert_q),
		.old_row  (old_row),
		.row_pair (row_pair),
		.result   (result),
		.row_wr   (row_wr),
		.row_nxt  (row_nxt)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, out_q.scan_row, out_q.irq, out_q.bad_access, out_q.read_data};

	a_row_write: assert property (@(posedge clk) disable iff (!arst_n)
		row_wr.we |-> (s1_adv && item_s1.cmd == CMD_TICK))
		else $error("row store written outside an advancing tick");

	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && m_valid_q && !m_tready))
		else $error("input stalled without a full pipeline");

	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> m_valid_q)
		else $error("advanced item produced no result");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keypad_matrix_scan_controller_top: queue-fed stream
// driver, clocked result monitor and a per-item predictor of the register file and scanner.
// Depends on kmsc_pkg and the block's RTL only.
module testbench;
	import kmsc_pkg::*;

	localparam logic [1:0]        CMD_NONE       = 2'd3;
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED  = 7'h4C;
	localparam logic [ADDR_W-1:0] ADDR_UNALIGNED = 7'h11;
	localparam logic [ADDR_W-1:0] ADDR_TOP       = 7'h7F;
	localparam int                CTRL_CONT      = 0;
	localparam int                CTRL_RUN       = 1;
	localparam int                IDLE_LIMIT     = 3000;
	localparam int                HOLD_CYCLES    = 400;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
		logic [ROW_W-1:0]  keys;
	} kp_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // addr[6:0], write_data[38:7], key_columns[54:39], pad
	logic [1:0]  s_tuser = '0;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // read_data[31:0], bad_access, irq, scan_row[37:34], pad

	kp_item_t item_q[$];
	result_t  response_q[$];

	// predictor copy of the block state
	logic [31:0]      kp_ctrl = '0;
	logic [31:0]      kp_size = '0;
	logic [1:0]       kp_status = '0;
	logic [2:0]       kp_irq_en = '0;
	logic [31:0]      kp_gpio_en = '0;
	logic [ROW_W-1:0] kp_rows[NUM_ROWS];
	logic [3:0]       kp_row_idx = '0;
	logic [CNT_W-1:0] kp_count = '0;
	logic             kp_running = 1'b0;
	logic             kp_invert = 1'b0;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;
	logic hold_arm = 1'b0;
	logic hold_done = 1'b0;
	int idle_cycles = 0;
	int n_err = 0;
	int n_in = 0;
	int n_out = 0;
	int n_scans = 0;
	int n_frames = 0;
	logic [ROW_W-1:0] last_keys = '0;

	keypad_matrix_scan_controller_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CNT_W-1:0] row_gap(logic [31:0] ctrl);
		return (ctrl[15:2] == '0) ? CNT_W'(1) : CNT_W'(ctrl[15:2]);
	endfunction

	function automatic result_t predict_response(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
			logic [DATA_W-1:0] wd, logic [ROW_W-1:0] keys);
		result_t          r;
		logic [3:0]       k;
		logic [19:0]      glitch;
		logic [ROW_W-1:0] rowv;
		int               nrows;
		r = '0;
		case (cmd)
			CMD_READ: begin
				if (addr >= ADDR_ROWS_LO && addr <= ADDR_ROWS_HI && addr[1:0] == 2'b00) begin
					k = 4'((addr - ADDR_ROWS_LO) >> 1);
					r.read_data = {kp_rows[4'(k + 4'd1)], kp_rows[k]};
				end else begin
					case (addr)
						ADDR_CONTROL:   r.read_data = kp_ctrl;
						ADDR_SIZE:      r.read_data = kp_size;
						ADDR_STATUS:    r.read_data = {30'd0, kp_status};
						ADDR_ENABLE:    r.read_data = {29'd0, kp_irq_en};
						ADDR_GPIO_EN:   r.read_data = kp_gpio_en;
						ADDR_RSV_30, ADDR_RSV_34, ADDR_RSV_38, ADDR_RSV_3C,
						ADDR_GPIO_STAT, ADDR_RSV_48: r.read_data = '0;
						default:        r.bad_access = 1'b1;
					endcase
				end
			end
			CMD_WRITE: begin
				case (addr)
					ADDR_CONTROL: begin
						kp_ctrl = wd;
						kp_running = wd[CTRL_RUN];
						kp_count = wd[CTRL_RUN] ? CNT_W'(wd[31:16]) + row_gap(wd) : '0;
					end
					ADDR_SIZE:    kp_size = wd;
					ADDR_STATUS:  kp_status = kp_status & ~wd[1:0];
					ADDR_ENABLE:  kp_irq_en = wd[2:0];
					ADDR_GPIO_EN: kp_gpio_en = wd;
					ADDR_RSV_30, ADDR_RSV_34, ADDR_RSV_3C, ADDR_GPIO_STAT, ADDR_RSV_48: ;
					default:      r.bad_access = 1'b1;
				endcase
			end
			CMD_TICK: begin
				if (kp_running) begin
					if (kp_count <= CNT_W'(1)) begin
						n_scans++;
						glitch = 20'h80000 >> kp_row_idx;
						rowv = ~keys & ~glitch[15:0];
						if (kp_size[15:8] < 8'd16)
							rowv = rowv | (16'hFFFF << kp_size[11:8]);
						if (kp_invert)
							rowv = ~rowv;
						if (kp_rows[kp_row_idx] != rowv) begin
							kp_rows[kp_row_idx] = rowv;
							kp_status[1] = 1'b1;
						end
						nrows = (kp_size[7:0] > MAX_ROWS) ? MAX_ROWS : int'(kp_size[7:0]);
						if (int'(kp_row_idx) + 1 < nrows) begin
							kp_row_idx = kp_row_idx + 4'd1;
							kp_count = row_gap(kp_ctrl);
						end else begin
							n_frames++;
							kp_row_idx = '0;
							kp_status[0] = 1'b1;
							if (kp_ctrl[CTRL_CONT]) begin
								kp_count = CNT_W'(kp_ctrl[31:16]) + row_gap(kp_ctrl);
							end else begin
								kp_ctrl[1:0] = 2'b00;
								kp_running = 1'b0;
								kp_count = '0;
							end
						end
					end else begin
						kp_count = kp_count - CNT_W'(1);
					end
				end
			end
			default: ;
		endcase
		r.irq = |(kp_irq_en & {1'b0, kp_status});
		r.scan_row = kp_row_idx;
		return r;
	endfunction

	// stream driver: hold valid until taken, predict on acceptance
	always @(posedge clk) begin : drive_p
		kp_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				response_q.push_back(predict_response(s_tuser, s_tdata[6:0], s_tdata[38:7],
					s_tdata[54:39]));
				n_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (item_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = item_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= nxt.cmd;
					s_tdata <= {1'b0, nxt.keys, nxt.wdata, nxt.addr};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : hold_p
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin : watch_p
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_out++;
				if (response_q.size() == 0) begin
					n_err++;
					if (n_err < 40)
						$display("%0t: result with nothing expected, got %h", $time, m_tdata);
				end else begin
					want = response_q.pop_front();
					if (m_tdata[31:0] !== want.read_data) begin
						n_err++;
						if (n_err < 40)
							$display("%0t: read_data expected %h got %h", $time,
								want.read_data, m_tdata[31:0]);
					end
					if (m_tdata[32] !== want.bad_access) begin
						n_err++;
						if (n_err < 40)
							$display("%0t: bad_access expected %b got %b", $time,
								want.bad_access, m_tdata[32]);
					end
					if (m_tdata[33] !== want.irq) begin
						n_err++;
						if (n_err < 40)
							$display("%0t: irq expected %b got %b", $time, want.irq, m_tdata[33]);
					end
					if (m_tdata[37:34] !== want.scan_row) begin
						n_err++;
						if (n_err < 40)
							$display("%0t: scan_row expected %0d got %0d", $time,
								want.scan_row, m_tdata[37:34]);
					end
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : watchdog_p
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic put(logic [1:0] c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
			logic [ROW_W-1:0] k);
		item_q.push_back('{cmd: c, addr: a, wdata: d, keys: k});
	endtask

	function automatic logic [ADDR_W-1:0] any_mapped_addr();
		case ($urandom_range(10))
			0:       return ADDR_CONTROL;
			1:       return ADDR_SIZE;
			2:       return ADDR_STATUS;
			3:       return ADDR_ENABLE;
			4:       return ADDR_GPIO_EN;
			5:       return ADDR_GPIO_STAT;
			6:       return ADDR_RSV_30;
			7:       return ADDR_RSV_38;
			8:       return ADDR_RSV_48;
			default: return ADDR_ROWS_LO + ADDR_W'(4 * $urandom_range(7));
		endcase
	endfunction

	// mostly setup-then-scan sessions, the rest random noise
	task automatic push_random(int n);
		int pushed;
		int ticks;
		logic [31:0] sz;
		logic [31:0] ctrl;
		logic [ROW_W-1:0] k;
		pushed = 0;
		while (pushed < n) begin
			if ($urandom_range(9) < 8) begin
				sz = $urandom;
				sz[7:0] = ($urandom_range(7) == 0) ? 8'($urandom_range(20)) : 8'($urandom_range(6));
				if ($urandom_range(3) != 0)
					sz[15:8] = 8'($urandom_range(20));
				put(CMD_WRITE, ADDR_SIZE, sz, ROW_W'($urandom));
				put(CMD_WRITE, ADDR_ENABLE, $urandom, ROW_W'($urandom));
				ctrl = {16'($urandom_range(3)), 14'($urandom_range(3)), 1'b1, 1'($urandom)};
				put(CMD_WRITE, ADDR_CONTROL, ctrl, ROW_W'($urandom));
				ticks = $urandom_range(8, 40);
				pushed += 3 + ticks;
				repeat (ticks) begin
					case ($urandom_range(11))
						0: put(CMD_READ, any_mapped_addr(), $urandom, ROW_W'($urandom));
						1: put(CMD_WRITE, ADDR_STATUS, $urandom, ROW_W'($urandom));
						2: put(CMD_READ, ADDR_STATUS, $urandom, ROW_W'($urandom));
						default: begin
							case ($urandom_range(3))
								0:       k = '0;
								1:       k = '1;
								2:       k = last_keys;
								default: k = ROW_W'($urandom);
							endcase
							last_keys = k;
							put(CMD_TICK, ADDR_W'($urandom), $urandom, k);
						end
					endcase
				end
				if ($urandom_range(3) == 0) begin
					put(CMD_WRITE, ADDR_CONTROL, $urandom & ~32'h2, ROW_W'($urandom));
					pushed++;
				end
			end else begin
				repeat ($urandom_range(1, 5)) begin
					put(2'($urandom), $urandom_range(1) ? any_mapped_addr() : ADDR_W'($urandom),
						$urandom, ROW_W'($urandom));
					pushed++;
				end
			end
		end
	endtask

	task automatic settle();
		do @(negedge clk);
		while (item_q.size() > 0 || s_tvalid || response_q.size() > 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_invert(logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		kp_invert = v;
		@(negedge clk);
	endtask

	task automatic set_idling(int tx, int rx);
		@(posedge clk);
		tx_idle_pct <= tx;
		rx_stall_pct <= rx;
		@(negedge clk);
	endtask

	initial begin : stim_p
		foreach (kp_rows[i])
			kp_rows[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		set_invert(1'b0);

		put(CMD_READ, ADDR_CONTROL, '0, '0);
		put(CMD_READ, ADDR_RSV_38, '1, '1);
		put(CMD_READ, ADDR_UNMAPPED, '0, '0);
		put(CMD_READ, ADDR_UNALIGNED, '0, '0);
		put(CMD_READ, ADDR_TOP, '0, '0);
		put(CMD_WRITE, ADDR_ROWS_LO, '1, '0);
		put(CMD_WRITE, ADDR_RSV_38, '1, '0);
		put(CMD_WRITE, ADDR_GPIO_STAT, '1, '0);
		put(CMD_WRITE, ADDR_GPIO_EN, '1, '0);
		put(CMD_READ, ADDR_GPIO_EN, '0, '0);
		put(CMD_TICK, '0, '0, '1);
		put(CMD_NONE, ADDR_TOP, '1, '1);
		put(CMD_WRITE, ADDR_ENABLE, '1, '0);
		// zero rows, four columns, single shot with zero delays
		put(CMD_WRITE, ADDR_SIZE, 32'h0000_0400, '0);
		put(CMD_WRITE, ADDR_CONTROL, 32'h0000_0002, '0);
		put(CMD_TICK, '0, '0, '0);
		put(CMD_TICK, '0, '0, '1);
		// row count saturates, no forced columns, continuous
		put(CMD_WRITE, ADDR_SIZE, 32'h0000_FF14, '0);
		put(CMD_WRITE, ADDR_CONTROL, 32'h0000_0007, '0);
		put(CMD_TICK, '0, '0, '1);
		put(CMD_TICK, '0, '0, 16'hA5A5);
		put(CMD_READ, ADDR_ROWS_HI, '0, '0);
		put(CMD_WRITE, ADDR_STATUS, '1, '0);
		put(CMD_READ, ADDR_STATUS, '0, '0);
		put(CMD_WRITE, ADDR_CONTROL, '0, '0);
		settle();

		set_invert(1'b1);
		push_random(350);
		settle();

		set_invert(1'b0);
		set_idling(82, 0);
		push_random(350);
		settle();

		set_invert(1'b1);
		set_idling(0, 82);
		push_random(350);
		settle();

		// long result hold-off with the sender still offering, then a full drain pause
		set_invert(1'b0);
		set_idling(19, 19);
		push_random(175);
		@(posedge clk);
		hold_arm <= 1'b1;
		do @(negedge clk);
		while (item_q.size() > 0 || s_tvalid || response_q.size() > 0);
		push_random(175);
		settle();

		set_invert(1'b1);
		set_idling(0, 0);
		push_random(350);
		settle();
		repeat (20) @(negedge clk);

		if (response_q.size() > 0)
			n_err++;
		$display("covered %0d items and %0d results: %0d rows scanned, %0d frames completed",
			n_in, n_out, n_scans, n_frames);
		$display("both column polarities, four idle/stall mixes, one %0d-cycle hold-off",
			HOLD_CYCLES);
		if (n_err == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/kmsc_pkg.sv
src/kmsc_ram.sv
src/kmsc_core.sv
src/keypad_matrix_scan_controller_top.sv
tb/testbench.sv
